@@ hw/rtl/u256alu_pkg.sv @@
// Package for the 256-bit unsigned ALU: opcodes, widths, command and status types.
// No dependencies.
package u256alu_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned NUM_W   = 256;
    localparam int unsigned NWORDS  = 4;
    localparam int unsigned CNT_W   = 8;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MOD  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_XOR  = 4'd7;
    localparam logic [3:0] OP_NOT  = 4'd8;
    localparam logic [3:0] OP_SHL  = 4'd9;
    localparam logic [3:0] OP_SHR  = 4'd10;
    localparam logic [3:0] OP_LESS = 4'd11;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture operands, clear accumulators
        logic mul_step;   // one 32x32 digit product of A and B
        logic div_step;   // one quotient bit
        logic finish;     // copy result into output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] op;
        logic       b_zero;
    } dp_sts_t;

endpackage

@@ hw/rtl/u256alu_dp.sv @@
// Datapath of the 256-bit ALU: operand registers, shared shift/add/sub logic,
// a 32x32 multiply-accumulate digit step and a restoring divider step.
// Depends on u256alu_pkg.
module u256alu_dp
(
    input  logic                       clk,
    input  u256alu_pkg::dp_cmd_t       cmd_i,
    input  logic [u256alu_pkg::CNT_W-1:0] cnt,
    input  logic [3:0]                 op_in,
    input  logic [255:0]               a_in,
    input  logic [255:0]               b_in,
    input  logic [8:0]                 sh_in,
    output u256alu_pkg::dp_sts_t       sts,
    output logic [255:0]               res,
    output logic                       lt,
    output logic                       dz
);

    logic [3:0]   op_reg;
    logic [255:0] a_reg, b_reg, acc_reg, q_reg;
    logic [8:0]   sh_reg;
    logic [255:0] acc_next, q_next, r_fast;
    logic         lt_fast, b_zero;
    logic [31:0]  a_dig, b_dig;
    logic [63:0]  prod;
    logic [3:0]   dig_pos;
    logic [255:0] prod_sh;
    logic [256:0] rshift, rdiff;
    logic         a_bit;

    assign b_zero = (b_reg == '0);
    assign sts.op = op_reg;
    assign sts.b_zero = b_zero;
    assign lt_fast = (a_reg < b_reg);

    always_comb
    begin
        case (op_reg)
            u256alu_pkg::OP_ADD: r_fast = a_reg + b_reg;
            u256alu_pkg::OP_SUB: r_fast = a_reg - b_reg;
            u256alu_pkg::OP_AND: r_fast = a_reg & b_reg;
            u256alu_pkg::OP_OR:  r_fast = a_reg | b_reg;
            u256alu_pkg::OP_XOR: r_fast = a_reg ^ b_reg;
            u256alu_pkg::OP_NOT: r_fast = ~a_reg;
            u256alu_pkg::OP_SHL: r_fast = sh_reg[8] ? '0 : a_reg << sh_reg[7:0];
            u256alu_pkg::OP_SHR: r_fast = sh_reg[8] ? '0 : a_reg >> sh_reg[7:0];
            default:             r_fast = '0;
        endcase
    end

    // multiply: acc += (A digit i * B digit j) << 32*(i+j), i = cnt[5:3], j = cnt[2:0]
    // products that land at or above bit 256 shift out and drop
    always_comb
    begin
        a_dig   = a_reg[cnt[5:3]*32 +: 32];
        b_dig   = b_reg[cnt[2:0]*32 +: 32];
        prod    = {32'd0, a_dig} * {32'd0, b_dig};
        dig_pos = {1'b0, cnt[5:3]} + {1'b0, cnt[2:0]};
        prod_sh = {192'd0, prod} << {dig_pos, 5'd0};
    end

    // division: cnt counts down bit index 255..0
    always_comb
    begin
        a_bit  = a_reg[cnt];
        rshift = {acc_reg, a_bit};
        rdiff  = rshift - {1'b0, b_reg};
    end

    always_comb
    begin
        acc_next = acc_reg;
        q_next   = q_reg;
        if (cmd_i.mul_step)
        begin
            acc_next = acc_reg + prod_sh;
        end
        if (cmd_i.div_step)
        begin
            if (!rdiff[256])
            begin
                acc_next = rdiff[255:0];
                q_next   = {q_reg[254:0], 1'b1};
            end
            else
            begin
                acc_next = rshift[255:0];
                q_next   = {q_reg[254:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            op_reg  <= op_in;
            a_reg   <= a_in;
            b_reg   <= b_in;
            sh_reg  <= sh_in;
            acc_reg <= '0;
            q_reg   <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            q_reg   <= q_next;
        end
        if (cmd_i.finish)
        begin
            lt <= (op_reg == u256alu_pkg::OP_LESS) && lt_fast;
            dz <= ((op_reg == u256alu_pkg::OP_DIV) || (op_reg == u256alu_pkg::OP_MOD))
                  && b_zero;
            if (op_reg == u256alu_pkg::OP_MUL)
                res <= acc_reg;
            else if ((op_reg == u256alu_pkg::OP_DIV) || (op_reg == u256alu_pkg::OP_MOD))
                res <= b_zero ? '0 : ((op_reg == u256alu_pkg::OP_DIV) ? q_reg : acc_reg);
            else
                res <= r_fast;
        end
    end

endmodule

@@ hw/rtl/u256alu_ctrl.sv @@
// Controller of the 256-bit ALU: sequences load, multiply digits, divide bits
// and the output handshake. Depends on u256alu_pkg.
module u256alu_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_fire,
    input  logic                          out_fire,
    input  u256alu_pkg::dp_sts_t          sts,
    output u256alu_pkg::dp_cmd_t          cmd_o,
    output logic [u256alu_pkg::CNT_W-1:0] cnt,
    output logic                          in_rdy,
    output logic                          out_vld
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [u256alu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic out_vld_reg, out_vld_next;

    assign cnt     = cnt_reg;
    // a fresh word may enter while the previous result waits; its finish holds until the output clears
    assign in_rdy  = (state_reg == S_IDLE);
    assign out_vld = out_vld_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        out_vld_next = out_vld_reg && !out_fire;
        cmd_o        = '0;
        cmd_o.load   = in_fire;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.op == u256alu_pkg::OP_MUL)
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else if (((sts.op == u256alu_pkg::OP_DIV) || (sts.op == u256alu_pkg::OP_MOD))
                         && !sts.b_zero)
                begin
                    cnt_next   = '1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                cmd_o.mul_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[5:0] == 6'd63)
                    state_next = S_FIN;
            end
            S_DIV:
            begin
                cmd_o.div_step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_vld_reg || out_fire)
                begin
                    cmd_o.finish = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

@@ hw/rtl/uint256_alu_unit.sv @@
// Top level of the 256-bit unsigned ALU: stream ports, controller and datapath.
// Depends on u256alu_pkg, u256alu_ctrl, u256alu_dp.
//
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | cmd[3:0], a_w0..a_w3, b_w0..b_w3, shift_amount[8:0], pad to 536
//  m_axis  | out | res_w0..res_w3, less_than, div_zero, pad to 264
//
// Sequence per word: load, decode, then finish for logic, add, sub, shifts, compare, unused
// opcodes and a zero divisor; multiply first runs 64 32x32 digit-product steps; divide and
// modulo first run a restoring division, one quotient bit per cycle.
// A new word is taken once the previous one has reached the output register.
// Reset clears the controller and the output valid; a stalled result holds.
module uint256_alu_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [535:0] s_axis_tdata,  // cmd, a_w0..a_w3, b_w0..b_w3, shift_amount
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [263:0] m_axis_tdata   // res_w0..res_w3, less_than, div_zero
);

    u256alu_pkg::dp_cmd_t dcmd;
    u256alu_pkg::dp_sts_t dsts;
    logic [u256alu_pkg::CNT_W-1:0] cnt;
    logic [255:0] res;
    logic lt, dz, in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    u256alu_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .sts(dsts), .cmd_o(dcmd), .cnt(cnt), .in_rdy(s_axis_tready),
        .out_vld(m_axis_tvalid)
    );

    u256alu_dp u_dp
    (
        .clk(clk), .cmd_i(dcmd), .cnt(cnt),
        .op_in(s_axis_tdata[3:0]), .a_in(s_axis_tdata[259:4]),
        .b_in(s_axis_tdata[515:260]), .sh_in(s_axis_tdata[524:516]),
        .sts(dsts), .res(res), .lt(lt), .dz(dz)
    );

    assign m_axis_tdata = {6'd0, dz, lt, res};

    // a result never overflows: no finish while an unread result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !dcmd.finish)
        else $error("result overwritten while stalled");

    // only one kind of work step at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({dcmd.mul_step, dcmd.div_step, dcmd.finish, dcmd.load}) <= 1)
        else $error("overlapping datapath commands");

    // flags are exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[256] && m_axis_tdata[257]))
        else $error("less_than and div_zero both set");

endmodule
